[rtl/bdq_pkg.sv]
// Package with shared types and constants for the byte double-ended queue.
package bdq_pkg;

  // Default number of byte entries in the ring store.
  localparam int unsigned DefDepth = 16;

  // Widths of the fixed transaction fields.
  localparam int unsigned ByteW = 8;
  localparam int unsigned OccW  = 5;

  // Operation requested by one input transaction.
  typedef enum logic [1:0] {
    ModePushFront = 2'd0,
    ModePushBack  = 2'd1,
    ModePopFront  = 2'd2,
    ModePopBack   = 2'd3
  } mode_e;

  // Outcome reported with every result.
  typedef enum logic [1:0] {
    StatusOk    = 2'd0,
    StatusEmpty = 2'd1,
    StatusFull  = 2'd2
  } status_e;

  // Result stage contents handed from the controller to the top level.
  typedef struct packed {
    logic                valid;
    logic                from_ram;
    status_e             status;
    logic [OccW-1:0]     occupancy;
  } res_ctrl_t;

endpackage

[rtl/bdq_ram.sv]
// Generic single-port synchronous RAM with a registered read.
module bdq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port share one address.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/bdq_ctrl.sv]
// Controller holding the front index and entry count and driving the ring store.
module bdq_ctrl #(
  parameter int unsigned Depth = bdq_pkg::DefDepth
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  bdq_pkg::mode_e           mode_i,
  input  logic [bdq_pkg::ByteW-1:0] push_byte_i,
  output logic                     mem_en_o,
  output logic                     mem_we_o,
  output logic [$clog2(Depth)-1:0] mem_addr_o,
  output logic [bdq_pkg::ByteW-1:0] mem_wdata_o,
  output bdq_pkg::res_ctrl_t       res_o
);

  import bdq_pkg::*;

  localparam int unsigned IdxW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [IdxW-1:0] front_q, front_d;
  logic [CntW-1:0] count_q, count_d;
  res_ctrl_t       res_q, res_d;

  logic            full;
  logic            empty;
  logic [IdxW-1:0] front_dec;
  logic [IdxW-1:0] front_inc;
  logic [IdxW-1:0] back_pos;
  logic [IdxW-1:0] last_pos;

  // Ring position a given number of entries behind the front, wrapping once.
  function automatic logic [IdxW-1:0] ring_pos(input logic [IdxW-1:0] front,
                                               input logic [IdxW-1:0] off);
    logic [IdxW:0] sum;
    sum = {1'b0, front} + {1'b0, off};
    if (sum >= (IdxW+1)'(Depth)) begin
      sum = sum - (IdxW+1)'(Depth);
    end
    return sum[IdxW-1:0];
  endfunction

  // Queue bounds and the ring positions every operation may need.
  assign full      = (count_q == CntW'(Depth));
  assign empty     = (count_q == '0);
  assign front_dec = (front_q == '0) ? IdxW'(Depth - 1) : front_q - IdxW'(1);
  assign front_inc = ring_pos(front_q, IdxW'(1));
  assign back_pos  = ring_pos(front_q, count_q[IdxW-1:0]);
  assign last_pos  = ring_pos(front_q, IdxW'(count_q - CntW'(1)));

  // Next state, memory request and result for the transaction being accepted.
  always_comb begin
    front_d       = front_q;
    count_d       = count_q;
    mem_en_o      = 1'b0;
    mem_we_o      = 1'b0;
    mem_addr_o    = front_q;
    mem_wdata_o   = push_byte_i;
    res_d         = '0;
    res_d.status  = StatusOk;
    if (accept_i) begin
      res_d.valid = 1'b1;
      case (mode_i)
        ModePushFront: begin
          if (full) begin
            res_d.status = StatusFull;
          end else begin
            front_d    = front_dec;
            count_d    = count_q + CntW'(1);
            mem_en_o   = 1'b1;
            mem_we_o   = 1'b1;
            mem_addr_o = front_dec;
          end
        end
        ModePushBack: begin
          if (full) begin
            res_d.status = StatusFull;
          end else begin
            count_d    = count_q + CntW'(1);
            mem_en_o   = 1'b1;
            mem_we_o   = 1'b1;
            mem_addr_o = back_pos;
          end
        end
        ModePopFront: begin
          if (empty) begin
            res_d.status = StatusEmpty;
          end else begin
            front_d        = front_inc;
            count_d        = count_q - CntW'(1);
            mem_en_o       = 1'b1;
            mem_addr_o     = front_q;
            res_d.from_ram = 1'b1;
          end
        end
        default: begin
          if (empty) begin
            res_d.status = StatusEmpty;
          end else begin
            count_d        = count_q - CntW'(1);
            mem_en_o       = 1'b1;
            mem_addr_o     = last_pos;
            res_d.from_ram = 1'b1;
          end
        end
      endcase
    end
    // Occupancy is the new count truncated to the occupancy field width.
    res_d.occupancy = OccW'(count_d);
  end

  // Ring indices, count and the result stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
      res_q   <= '0;
    end else begin
      front_q <= front_d;
      count_q <= count_d;
      res_q   <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

[rtl/byte_double_ended_queue_top.sv]
// Top level of the byte double-ended queue: a ring store with front index and count.
//
// One operation (push front, push back, pop front, pop back) is accepted on every
// clock edge at which start is high; busy is never raised. Each transaction gives
// exactly one result, shown on the result ports with valid_o high for one cycle, in the
// cycle after acceptance, through the result stage register and the registered read
// of the ring store memory. The receiver cannot stall results. A pop from an empty queue or a push to
// a full one reports its status and leaves the queue untouched. The store needs no
// clearing after reset, since only entries inside the count are ever read.
module byte_double_ended_queue_top #(
  parameter int unsigned DEPTH = bdq_pkg::DefDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  bdq_pkg::mode_e                mode_i,
  input  logic [bdq_pkg::ByteW-1:0]     push_byte_i,
  output logic                          valid_o,
  output logic [bdq_pkg::ByteW-1:0]     popped_byte_o,
  output bdq_pkg::status_e              status_o,
  output logic [bdq_pkg::OccW-1:0]      occupancy_o
);

  import bdq_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);

  logic             accept;
  logic             mem_en;
  logic             mem_we;
  logic [IdxW-1:0]  mem_addr;
  logic [ByteW-1:0] mem_wdata;
  logic [ByteW-1:0] mem_rdata;
  res_ctrl_t        res;

  // Every operation updates the state registers when it is accepted, so busy is never raised.
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  bdq_ctrl #(
    .Depth (DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .mode_i      (mode_i),
    .push_byte_i (push_byte_i),
    .mem_en_o    (mem_en),
    .mem_we_o    (mem_we),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .res_o       (res)
  );

  bdq_ram #(
    .Width (ByteW),
    .Depth (DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // Result ports; the popped byte is the memory read register, or zero unless a pop read the ring.
  assign valid_o       = res.valid;
  assign popped_byte_o = res.from_ram ? mem_rdata : '0;
  assign status_o      = res.status;
  assign occupancy_o   = res.occupancy;

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the byte double-ended queue: directed corner cases, then biased random traffic.
module tb;
  import bdq_pkg::*;

  localparam int unsigned Depth      = DefDepth;
  localparam int unsigned CycleLimit = 200000;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  mode_e              mode_i;
  logic [ByteW-1:0]   push_byte_i;
  logic               valid_o;
  logic [ByteW-1:0]   popped_byte_o;
  status_e            status_o;
  logic [OccW-1:0]    occupancy_o;

  // One expected result of a queue operation.
  typedef struct packed {
    logic [ByteW-1:0] popped;
    status_e          status;
    logic [OccW-1:0]  occupancy;
  } deque_outcome_t;

  // Expected results in order of acceptance.
  deque_outcome_t outcome_q[$];
  deque_outcome_t seen_outcome;

  // Shadow copy of the queue contents.
  logic [ByteW-1:0] shadow_ring [Depth];
  int unsigned      shadow_head;
  int unsigned      shadow_fill;

  int unsigned ops_sent;
  int unsigned full_rejects;
  int unsigned empty_rejects;
  int unsigned mismatches;
  int unsigned cycle_count;

  byte_double_ended_queue_top #(
    .DEPTH(Depth)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .mode_i       (mode_i),
    .push_byte_i  (push_byte_i),
    .valid_o      (valid_o),
    .popped_byte_o(popped_byte_o),
    .status_o     (status_o),
    .occupancy_o  (occupancy_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Applies one operation to the shadow queue and returns the result it should give.
  function automatic deque_outcome_t apply_deque_op(mode_e op, logic [ByteW-1:0] b);
    deque_outcome_t res;
    int unsigned    slot;
    res.popped = '0;
    res.status = StatusOk;
    case (op)
      ModePushFront: begin
        if (shadow_fill >= Depth) begin
          res.status = StatusFull;
        end else begin
          shadow_head = (shadow_head + Depth - 1) % Depth;
          shadow_ring[shadow_head] = b;
          shadow_fill++;
        end
      end
      ModePushBack: begin
        if (shadow_fill >= Depth) begin
          res.status = StatusFull;
        end else begin
          slot = (shadow_head + shadow_fill) % Depth;
          shadow_ring[slot] = b;
          shadow_fill++;
        end
      end
      ModePopFront: begin
        if (shadow_fill == 0) begin
          res.status = StatusEmpty;
        end else begin
          res.popped = shadow_ring[shadow_head];
          shadow_head = (shadow_head + 1) % Depth;
          shadow_fill--;
        end
      end
      default: begin
        if (shadow_fill == 0) begin
          res.status = StatusEmpty;
        end else begin
          slot = (shadow_head + shadow_fill - 1) % Depth;
          res.popped = shadow_ring[slot];
          shadow_fill--;
        end
      end
    endcase
    res.occupancy = OccW'(shadow_fill);
    return res;
  endfunction

  // Idle gap between transactions: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Drives one transaction, waits for it to be accepted and records its expected result.
  task automatic send_op(mode_e op, logic [ByteW-1:0] b, int unsigned gap);
    deque_outcome_t res;
    start       <= 1'b1;
    mode_i      <= op;
    push_byte_i <= b;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    res = apply_deque_op(op, b);
    outcome_q.push_back(res);
    ops_sent++;
    if (res.status == StatusFull) full_rejects++;
    if (res.status == StatusEmpty) empty_rejects++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Holds the sender off until every outstanding result has arrived.
  task automatic wait_drained();
    start <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
  endtask

  // Pops on an empty queue from both ends.
  task automatic test_empty_pops();
    send_op(ModePopFront, 8'hA5, pick_gap());
    send_op(ModePopBack, 8'h5A, pick_gap());
  endtask

  // Front push wraps the index below zero; two pops from the back then empty the queue.
  task automatic test_back_pops_to_empty();
    send_op(ModePushFront, 8'hFF, pick_gap());
    send_op(ModePushBack, 8'h00, pick_gap());
    send_op(ModePopBack, 8'h3C, pick_gap());
    send_op(ModePopBack, 8'hC3, pick_gap());
  endtask

  // Fills the queue from both ends, then pushes on a full queue at each end.
  task automatic test_fill_to_full();
    logic [ByteW-1:0] b;
    for (int unsigned i = 0; i < Depth; i++) begin
      b = (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : ByteW'($urandom_range(0, 255));
      send_op(i[0] ? ModePushBack : ModePushFront, b, pick_gap());
    end
    send_op(ModePushFront, 8'h81, pick_gap());
    send_op(ModePushBack, 8'h7E, pick_gap());
  endtask

  // Bursts of random operations, each burst leaning towards pushes, pops or neither.
  task automatic test_random_bursts(int unsigned items);
    int unsigned sent;
    int unsigned push_pct;
    int unsigned burst_len;
    bit          no_idle;
    mode_e       op;
    sent = 0;
    while (sent < items) begin
      case ($urandom_range(0, 2))
        0:       push_pct = 80;
        1:       push_pct = 20;
        default: push_pct = 50;
      endcase
      burst_len = $urandom_range(8, 48);
      no_idle   = ($urandom_range(0, 3) == 0);
      for (int unsigned i = 0; i < burst_len && sent < items; i++) begin
        if ($urandom_range(0, 99) < push_pct) begin
          op = $urandom_range(0, 1) ? ModePushBack : ModePushFront;
        end else begin
          op = $urandom_range(0, 1) ? ModePopBack : ModePopFront;
        end
        send_op(op, ByteW'($urandom_range(0, 255)), no_idle ? 0 : pick_gap());
        sent++;
      end
    end
  endtask

  // Compares each result with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (outcome_q.size() == 0) begin
        $display("%0t: unexpected result: popped %h status %0d occupancy %0d",
                 $time, popped_byte_o, status_o, occupancy_o);
        mismatches++;
      end else begin
        seen_outcome = outcome_q.pop_front();
        if (popped_byte_o !== seen_outcome.popped) begin
          $display("%0t: popped_byte expected %h actual %h",
                   $time, seen_outcome.popped, popped_byte_o);
          mismatches++;
        end
        if (status_o !== seen_outcome.status) begin
          $display("%0t: status expected %0d actual %0d",
                   $time, seen_outcome.status, status_o);
          mismatches++;
        end
        if (occupancy_o !== seen_outcome.occupancy) begin
          $display("%0t: occupancy expected %0d actual %0d",
                   $time, seen_outcome.occupancy, occupancy_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog against a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: run exceeded %0d cycles", $time, CycleLimit);
      $display("Mismatches found");
      $finish;
    end
  end

  // Reset, the test sequence and the final verdict.
  initial begin
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    mode_i      <= ModePushFront;
    push_byte_i <= '0;
    shadow_head = 0;
    shadow_fill = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_pops();
    test_back_pops_to_empty();
    test_fill_to_full();
    test_random_bursts(400);
    wait_drained();
    test_random_bursts(400);

    // Let the last results arrive, then keep watching for stray strobes.
    wait_drained();
    repeat (4) @(posedge clk_i);

    $display("Ran %0d queue operations; %0d pushes were refused as full and %0d pops as empty.",
             ops_sent, full_rejects, empty_rejects);
    $display("Covered empty and full queues at both ends, ring wrap and a sender pause.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/bdq_pkg.sv
rtl/bdq_ram.sv
rtl/bdq_ctrl.sv
rtl/byte_double_ended_queue_top.sv
verif/tb.sv
